// File: src/plrm_pkg.sv
// shared types, constants and codes for the positional list range minimum block
`default_nettype none
package plrm_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 16;
  localparam int VAL_W    = 32;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;

  localparam logic signed [VAL_W-1:0] EMPTY_MIN = 32'sh2000_0000;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_ERA  = 2'd2,
    OP_WR   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         p;
    logic signed [VAL_W-1:0]  value;
    logic                     q_en;
    logic [POS_W-1:0]         q_lo;
    logic [POS_W-1:0]         q_hi;
  } cell_ctl_t;

  typedef struct packed {
    logic                     found;
    logic signed [VAL_W-1:0]  min;
  } run_t;

endpackage
`default_nettype wire

// File: src/positional_list_range_min_top.sv
// top level: sequencer plus a row of list cells with a running-minimum chain
// edits: insert, erase, update pass execute and output states before the result is valid
// query: a walk state follows execute; the running minimum crosses one cell per cycle
// one item in work at a time; accept follows the queued result
// output register lets the next item enter while a result waits for out_tready
// reset: synchronous active-low rst_n empties the list; entries are not cleared
`default_nettype none
module positional_list_range_min_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // pos, pos_last, value
  input  logic [1:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // min_value, length, status, zero fill
  output logic        out_tuser   // range_empty
);
  import plrm_pkg::*;

  cell_ctl_t               ctl;
  run_t                    run_chain [CAPACITY+1];
  logic signed [VAL_W-1:0] cell_val  [CAPACITY];
  logic signed [VAL_W-1:0] out_min;
  logic [POS_W-1:0]        out_length;
  logic [STAT_W-1:0]       out_status;

  assign run_chain[0].found = 1'b0;
  assign run_chain[0].min   = EMPTY_MIN;

  plrm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_cmd      (in_tuser),
    .in_pos      (in_tdata[15:0]),
    .in_pos_last (in_tdata[31:16]),
    .in_value    (in_tdata[63:32]),
    .ctl         (ctl),
    .run_last    (run_chain[CAPACITY]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_min     (out_min),
    .out_empty   (out_tuser),
    .out_length  (out_length),
    .out_status  (out_status)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_inner
      assign right_v = cell_val[i+1];
    end
    plrm_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .ctl       (ctl),
      .left_val  (left_v),
      .right_val (right_v),
      .run_in    (run_chain[i]),
      .val       (cell_val[i]),
      .run_out   (run_chain[i+1])
    );
  end

  assign out_tdata = {6'd0, out_status, out_length, out_min};

endmodule
`default_nettype wire

// File: src/plrm_cell.sv
// one list cell: holds an entry, shifts with its neighbors, folds the running minimum
`default_nettype none
module plrm_cell (
  input  logic                               clk,
  input  logic [plrm_pkg::IDX_W-1:0]         idx,
  input  plrm_pkg::cell_ctl_t                ctl,
  input  logic signed [plrm_pkg::VAL_W-1:0]  left_val,
  input  logic signed [plrm_pkg::VAL_W-1:0]  right_val,
  input  plrm_pkg::run_t                     run_in,
  output logic signed [plrm_pkg::VAL_W-1:0]  val,
  output plrm_pkg::run_t                     run_out
);
  import plrm_pkg::*;

  logic signed [VAL_W-1:0] val_r, val_nxt;
  run_t                    run_r, run_nxt;
  logic                    in_range;
  logic [POS_W-1:0]        idx_ext;

  assign idx_ext = POS_W'(idx);

  always_comb begin
    val_nxt = val_r;
    unique case (ctl.op)
      OP_HOLD: val_nxt = val_r;
      OP_INS: begin
        if (idx == ctl.p) begin
          val_nxt = ctl.value;
        end else if (idx > ctl.p) begin
          val_nxt = left_val;
        end
      end
      OP_ERA: begin
        if (idx >= ctl.p) begin
          val_nxt = right_val;
        end
      end
      OP_WR: begin
        if (idx == ctl.p) begin
          val_nxt = ctl.value;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  assign in_range = ctl.q_en && (idx_ext >= ctl.q_lo) && (idx_ext <= ctl.q_hi);

  always_comb begin
    run_nxt = run_in;
    if (in_range && (!run_in.found || (val_r < run_in.min))) begin
      run_nxt.found = 1'b1;
      run_nxt.min   = val_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    run_r <= run_nxt;
  end

  assign val     = val_r;
  assign run_out = run_r;

endmodule
`default_nettype wire

// File: src/plrm_ctrl.sv
// command sequencer: decodes items, drives the cell row, times the minimum walk
`default_nettype none
module plrm_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [plrm_pkg::CMD_W-1:0]         in_cmd,
  input  logic [plrm_pkg::POS_W-1:0]         in_pos,
  input  logic [plrm_pkg::POS_W-1:0]         in_pos_last,
  input  logic signed [plrm_pkg::VAL_W-1:0]  in_value,
  output plrm_pkg::cell_ctl_t                ctl,
  input  plrm_pkg::run_t                     run_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [plrm_pkg::VAL_W-1:0]  out_min,
  output logic                               out_empty,
  output logic [plrm_pkg::POS_W-1:0]         out_length,
  output logic [plrm_pkg::STAT_W-1:0]        out_status
);
  import plrm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WALK = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  cmd_t                    cmd_r;
  logic [POS_W-1:0]        pos_r, pos_last_r;
  logic signed [VAL_W-1:0] value_r;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        walk_r, walk_nxt;

  logic                    q_en_r, q_en_nxt;
  logic [POS_W-1:0]        q_lo_r, q_lo_nxt, q_hi_r, q_hi_nxt;

  logic signed [VAL_W-1:0] res_min_r, res_min_nxt;
  logic                    res_empty_r, res_empty_nxt;
  logic [POS_W-1:0]        res_len_r, res_len_nxt;
  logic [STAT_W-1:0]       res_stat_r, res_stat_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_min_r;
  logic                    out_empty_r;
  logic [POS_W-1:0]        out_len_r;
  logic [STAT_W-1:0]       out_stat_r;

  logic                    in_fire, out_fire, out_load;
  logic [POS_W-1:0]        cnt_ext;
  logic                    full, present;
  cell_op_t                dec_op;
  logic [IDX_W-1:0]        dec_p;
  logic [CNT_W-1:0]        dec_count;
  logic [STAT_W-1:0]       dec_stat;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  assign cnt_ext = POS_W'(count_r);
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign present = (pos_r < cnt_ext);

  // list edit decode
  always_comb begin
    dec_op    = OP_HOLD;
    dec_p     = pos_r[IDX_W-1:0];
    dec_count = count_r;
    dec_stat  = STAT_OK;
    unique case (cmd_r)
      CMD_INSERT: begin
        if (full) begin
          dec_stat = STAT_FULL;
        end else begin
          dec_op    = OP_INS;
          dec_p     = present ? pos_r[IDX_W-1:0] : count_r[IDX_W-1:0];
          dec_count = count_r + CNT_W'(1);
        end
      end
      CMD_ERASE: begin
        if (present) begin
          dec_op    = OP_ERA;
          dec_count = count_r - CNT_W'(1);
        end else begin
          dec_stat = STAT_ABSENT;
        end
      end
      CMD_UPDATE: begin
        if (present) begin
          dec_op = OP_WR;
        end else if (full) begin
          dec_stat = STAT_FULL;
        end else begin
          dec_op    = OP_INS;
          dec_p     = count_r[IDX_W-1:0];
          dec_count = count_r + CNT_W'(1);
          dec_stat  = STAT_ABSENT;
        end
      end
      CMD_QUERY: dec_op = OP_HOLD;
      default:   dec_op = OP_HOLD;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    walk_nxt      = walk_r;
    q_en_nxt      = q_en_r;
    q_lo_nxt      = q_lo_r;
    q_hi_nxt      = q_hi_r;
    res_min_nxt   = res_min_r;
    res_empty_nxt = res_empty_r;
    res_len_nxt   = res_len_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_r == CMD_QUERY) begin
          q_en_nxt  = (count_r != '0) && (pos_r <= pos_last_r) && present;
          q_lo_nxt  = pos_r;
          q_hi_nxt  = (pos_last_r < cnt_ext) ? pos_last_r : (cnt_ext - POS_W'(1));
          walk_nxt  = '0;
          state_nxt = S_WALK;
        end else begin
          count_nxt     = dec_count;
          res_min_nxt   = '0;
          res_empty_nxt = 1'b0;
          res_len_nxt   = POS_W'(dec_count);
          res_stat_nxt  = dec_stat;
          state_nxt     = S_OUT;
        end
      end
      S_WALK: begin
        if (walk_r == CNT_W'(CAPACITY)) begin
          res_min_nxt   = run_last.found ? run_last.min : EMPTY_MIN;
          res_empty_nxt = !run_last.found;
          res_len_nxt   = cnt_ext;
          res_stat_nxt  = STAT_OK;
          state_nxt     = S_OUT;
        end else begin
          walk_nxt = walk_r + CNT_W'(1);
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      walk_r      <= '0;
      q_en_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      walk_r      <= walk_nxt;
      q_en_r      <= q_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r      <= cmd_t'(in_cmd);
      pos_r      <= in_pos;
      pos_last_r <= in_pos_last;
      value_r    <= in_value;
    end
    q_lo_r      <= q_lo_nxt;
    q_hi_r      <= q_hi_nxt;
    res_min_r   <= res_min_nxt;
    res_empty_r <= res_empty_nxt;
    res_len_r   <= res_len_nxt;
    res_stat_r  <= res_stat_nxt;
    if (out_load) begin
      out_min_r   <= res_min_r;
      out_empty_r <= res_empty_r;
      out_len_r   <= res_len_r;
      out_stat_r  <= res_stat_r;
    end
  end

  // edits reach the cells only in the execute cycle
  always_comb begin
    ctl.op    = (state_r == S_EXEC) ? dec_op : OP_HOLD;
    ctl.p     = dec_p;
    ctl.value = value_r;
    ctl.q_en  = q_en_r;
    ctl.q_lo  = q_lo_r;
    ctl.q_hi  = q_hi_r;
  end

  assign out_valid  = out_valid_r;
  assign out_min    = out_min_r;
  assign out_empty  = out_empty_r;
  assign out_length = out_len_r;
  assign out_status = out_stat_r;

endmodule
`default_nettype wire

// File: src/plrm_checker.sv
// port-level checks for the positional list range minimum block, bound to the top
`default_nettype none
module plrm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tuser
);
  import plrm_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous still in work");

  // empty range carries the marker value and ok status
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[31:0] == EMPTY_MIN) && (out_tdata[49:48] == STAT_OK))
    else $error("empty range with wrong minimum or status");

  // length bounded, status code valid and zero fill clear
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[47:32] <= POS_W'(CAPACITY)) &&
                   (out_tdata[49:48] != 2'd3) && (out_tdata[55:50] == 6'd0))
    else $error("length or status out of range");

endmodule

bind positional_list_range_min_top plrm_checker u_plrm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
